// File: src/min_falling_path_sum_unit_assert.svh
// Assertion macros for the minimum falling path sum unit.
// Included by the top level; depends on nothing else.
`ifndef MIN_FALLING_PATH_SUM_UNIT_ASSERT_SVH
`define MIN_FALLING_PATH_SUM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check that is skipped while reset is asserted.
`define MFPS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MFPS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define MFPS_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define MFPS_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// File: src/mfps_pkg.sv
// Shared types, constants and the saturating adder for the path sum unit.
// Depends on nothing; used by mfps_path_alu and the top level.
package mfps_pkg;

  // One path sum, signed 32 bits.
  typedef logic signed [31:0] sum_t;

  localparam sum_t SUM_MAX = 32'sh7FFF_FFFF;
  localparam sum_t SUM_MIN = 32'sh8000_0000;

  // Control that travels with a cell into the row minimum stage.
  typedef struct packed {
    logic valid;
    logic first_col;
    logic last;
  } s2_ctrl_t;

  // Clamp a 33-bit sum into the 32-bit signed range.
  function automatic sum_t sat_sum(input logic signed [32:0] s);
    sum_t res;
    if (s > 33'sh0_7FFF_FFFF) begin
      res = SUM_MAX;
    end else if (s < -33'sh0_8000_0000) begin
      res = SUM_MIN;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

endpackage

// File: src/mfps_path_alu.sv
// Path sum of one cell: least of the upper neighbors plus the cell value (the value alone on the first row).
// Depends on mfps_pkg for the sum type and the saturating adder.
module mfps_path_alu (
  input  logic                 first_row,
  input  logic                 use_right,
  input  logic signed [15:0]   cell_value,
  input  mfps_pkg::sum_t       left_mid_min,
  input  mfps_pkg::sum_t       right_val,
  output mfps_pkg::sum_t       path_sum
);

  mfps_pkg::sum_t          best;
  logic signed [32:0]      raw_sum;

  // The left/middle minimum is registered with the previous cell; only the right one is compared here.
  always_comb begin
    if (use_right && (right_val < left_mid_min)) begin
      best = right_val;
    end else begin
      best = left_mid_min;
    end
    raw_sum = {{17{cell_value[15]}}, cell_value} + {best[31], best};
    if (first_row) begin
      path_sum = {{16{cell_value[15]}}, cell_value};
    end else begin
      path_sum = mfps_pkg::sat_sum(raw_sum);
    end
  end

endmodule

// File: src/min_falling_path_sum_unit.sv
// Minimum falling path sum unit: top level with row buffer and output stage.
// Depends on mfps_pkg, mfps_path_alu and min_falling_path_sum_unit_assert.svh.
//
// Usage:
//   Matrix cells stream in row-major order on the in_ channel (valid/ready),
//   one cell per cycle while in_ready is high. in_end_of_matrix marks the final cell; the
//   least path sum of the last (possibly partial) row then appears on the
//   out_ channel. The row width is written through cfg_wr_en/cfg_num_cols
//   while the unit is idle; a write abandons any matrix in progress. Zero acts
//   as one and widths above MAX_COLS act as MAX_COLS.
//   Result path: the row minimum stage takes the final cell when it is accepted,
//   and the output register then takes the minimum from that stage.
//   Throughput: one cell per cycle while in_ready is high; the row buffer takes one
//   write and one look-ahead read per accepted cell.
//   Reset: width becomes one and the next cell starts a new matrix. The row
//   buffer is not cleared; every entry is written before it is read.
//   Stall: a waiting result holds in the output register while cells keep
//   flowing; only a second final cell behind it stops in_ready.
`include "min_falling_path_sum_unit_assert.svh"

module min_falling_path_sum_unit #(
  parameter int MAX_COLS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [8:0]           cfg_num_cols,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_cell_value,
  input  logic                 in_end_of_matrix,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_min_path_sum
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  typedef logic [AW-1:0] col_t;

  // Row buffer and its registered read port.
  mfps_pkg::sum_t mem [MAX_COLS];
  mfps_pkg::sum_t mem_q_r;

  col_t                col_r, col_nxt;
  col_t                wlast_r;
  col_t                rd_addr;
  logic                first_row_r, first_row_nxt;
  mfps_pkg::sum_t      a_r, a_nxt;
  mfps_pkg::sum_t      lmin_r, lmin_nxt;
  mfps_pkg::sum_t      col0_r;
  logic                fwd_r;
  mfps_pkg::sum_t      fwd_d_r;
  mfps_pkg::sum_t      b_cur;
  mfps_pkg::sum_t      cur;
  logic                wrap;
  logic                in_acc;

  mfps_pkg::s2_ctrl_t  s2_r, s2_nxt;
  mfps_pkg::sum_t      s2_cur_r;
  mfps_pkg::sum_t      row_min_r;
  mfps_pkg::sum_t      rm_new;
  logic                out_block;
  logic                s2_fire;
  logic                out_valid_r;
  mfps_pkg::sum_t      out_sum_r;

  // Handshake: only a second result behind a waiting one stops input.
  assign out_block = s2_r.last && out_valid_r && !out_ready;
  assign s2_fire   = s2_r.valid && !out_block;
  assign in_ready  = !(s2_r.valid && out_block);
  assign in_acc    = in_valid && in_ready;

  // Column bookkeeping and look-ahead read address.
  assign wrap    = (col_r == wlast_r);
  assign rd_addr = wrap ? col_t'(1) : (col_r + col_t'(2));
  assign b_cur   = fwd_r ? fwd_d_r : mem_q_r;

  mfps_path_alu u_alu (
    .first_row    (first_row_r),
    .use_right    (!wrap),
    .cell_value   (in_cell_value),
    .left_mid_min (lmin_r),
    .right_val    (b_cur),
    .path_sum     (cur)
  );

  // Window for the next cell: middle value and the left/middle minimum.
  always_comb begin
    if (wrap) begin
      a_nxt    = (col_r == '0) ? cur : col0_r;
      lmin_nxt = a_nxt;
    end else begin
      a_nxt    = b_cur;
      lmin_nxt = (b_cur < a_r) ? b_cur : a_r;
    end
    if (in_end_of_matrix || wrap) begin
      col_nxt = '0;
    end else begin
      col_nxt = col_r + col_t'(1);
    end
    if (in_end_of_matrix) begin
      first_row_nxt = 1'b1;
    end else if (wrap) begin
      first_row_nxt = 1'b0;
    end else begin
      first_row_nxt = first_row_r;
    end
  end

  // Control of the cell stage; a width write restarts the matrix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      wlast_r     <= '0;
      first_row_r <= 1'b1;
      fwd_r       <= 1'b0;
    end else if (cfg_wr_en) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
      if (cfg_num_cols == 9'd0) begin
        wlast_r <= '0;
      end else if (32'(cfg_num_cols) > 32'(MAX_COLS)) begin
        wlast_r <= AW'(MAX_COLS - 1);
      end else begin
        wlast_r <= AW'(32'(cfg_num_cols) - 32'd1);
      end
    end else if (in_acc) begin
      col_r       <= col_nxt;
      first_row_r <= first_row_nxt;
      fwd_r       <= (rd_addr == col_r);
    end
  end

  // Datapath registers of the cell stage.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r     <= a_nxt;
      lmin_r  <= lmin_nxt;
      fwd_d_r <= cur;
      if (col_r == '0) begin
        col0_r <= cur;
      end
    end
  end

  // Row buffer: write the new path sum, read ahead the right neighbor.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[col_r] <= cur;
      mem_q_r    <= mem[rd_addr];
    end
  end

  // Row minimum stage.
  always_comb begin
    if (in_ready) begin
      s2_nxt.valid     = in_acc;
      s2_nxt.first_col = (col_r == '0);
      s2_nxt.last      = in_end_of_matrix;
    end else begin
      s2_nxt = s2_r;
    end
    if (s2_r.first_col || (s2_cur_r < row_min_r)) begin
      rm_new = s2_cur_r;
    end else begin
      rm_new = row_min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r      <= '0;
      row_min_r <= mfps_pkg::SUM_MAX;
    end else begin
      s2_r <= s2_nxt;
      if (s2_fire) begin
        row_min_r <= rm_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_cur_r <= cur;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire && s2_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_r.last) begin
      out_sum_r <= rm_new;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_path_sum = out_sum_r;

  // Checks on the column counter and the stall path.
  `MFPS_ASSERT_ALWAYS(a_col_in_row, clk, (!rst_n || (col_r <= wlast_r)),
                      "column past row end")
  `MFPS_ASSERT(a_stall_cause, clk, rst_n,
               (!in_ready |-> (s2_r.valid && s2_r.last && out_valid_r)),
               "input stalled without a pending result")
  `MFPS_ASSERT(a_last_restarts, clk, rst_n,
               ((in_acc && in_end_of_matrix && !cfg_wr_en) |=>
                (s2_r.valid && s2_r.last && first_row_r && (col_r == '0))),
               "final cell did not restart the matrix")

endmodule

// File: bench/min_falling_path_sum_unit_tb.sv
// Self-checking testbench for min_falling_path_sum_unit: streams matrices cell by cell,
// predicts each least falling path sum and compares it with the out_ channel.
// Depends on mfps_pkg and min_falling_path_sum_unit.
module min_falling_path_sum_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_CAP = 256;

  // One matrix cell as it travels on the in_ channel.
  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } cell_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [8:0]         cfg_num_cols = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_cell_value = '0;
  logic               in_end_of_matrix = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_min_path_sum;

  cell_t          cells_pending[$];
  mfps_pkg::sum_t sums_due[$];
  logic [31:0]    cyc = '0;
  int             errors = 0;
  int             sums_checked = 0;
  int             cells_taken = 0;
  int             widths_written = 0;

  // Predictor state: one row of path sums plus the scan position.
  mfps_pkg::sum_t row_sums[ROW_CAP];
  mfps_pkg::sum_t left_sum;
  mfps_pkg::sum_t row_low;
  int unsigned    col_at;
  bit             top_row;
  logic [8:0]     width_reg;

  min_falling_path_sum_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_num_cols     (cfg_num_cols),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cell_value    (in_cell_value),
    .in_end_of_matrix (in_end_of_matrix),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_min_path_sum (out_min_path_sum)
  );

  always #5 clk = ~clk;

  // Begin a new matrix: first row next, column zero, no minimum yet.
  function automatic void restart_matrix();
    left_sum = '0;
    col_at = 0;
    top_row = 1'b1;
    row_low = mfps_pkg::SUM_MAX;
  endfunction

  // Row width in effect: zero acts as one, oversize widths clip to the buffer.
  function automatic int unsigned span();
    if (width_reg == 0) return 1;
    if (width_reg > ROW_CAP) return ROW_CAP;
    return 32'(width_reg);
  endfunction

  function automatic mfps_pkg::sum_t clamp_add(input logic signed [15:0] a,
                                               input mfps_pkg::sum_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(mfps_pkg::SUM_MAX)) return mfps_pkg::SUM_MAX;
    if (s < longint'(mfps_pkg::SUM_MIN)) return mfps_pkg::SUM_MIN;
    return mfps_pkg::sum_t'(s);
  endfunction

  // Fold one accepted cell into the row buffer; a final cell yields the row minimum.
  task automatic advance_path_sums(input logic signed [15:0] value, input logic last);
    int unsigned w;
    int unsigned j;
    mfps_pkg::sum_t old;
    mfps_pkg::sum_t best;
    mfps_pkg::sum_t here;
    w = span();
    j = (col_at >= w) ? 0 : col_at;
    old = row_sums[j];
    if (top_row) begin
      here = mfps_pkg::sum_t'(value);
    end else begin
      best = old;
      if (j > 0 && left_sum < best) best = left_sum;
      if (j + 1 < w && row_sums[j + 1] < best) best = row_sums[j + 1];
      here = clamp_add(value, best);
    end
    left_sum = old;
    row_sums[j] = here;
    if (j == 0 || here < row_low) row_low = here;
    j++;
    if (j >= w) begin
      j = 0;
      top_row = 1'b0;
    end
    col_at = j;
    if (last) begin
      sums_due.push_back(row_low);
      restart_matrix();
    end
  endtask

  // Random back-pressure, except in a quiet window while cyc[11:10] is 2'b11.
  function automatic bit take_break();
    if (cyc[11:10] == 2'b11) return 1'b0;
    return $urandom_range(99) < 24;
  endfunction

  function automatic int pick_cell_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(4))
        0: return 32767;
        1: return -32768;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    if (r < 40) return int'($urandom_range(40)) - 20;
    return int'($signed(16'($urandom)));
  endfunction

  task automatic push_cell(input int v, input bit last);
    cell_t c;
    c.value = v[15:0];
    c.last = last;
    cells_pending.push_back(c);
  endtask

  // Block until every queued cell is taken and every sum has come back, plus pipeline drain.
  // The test runs at the falling edge, after the driver and monitor have settled.
  task automatic wait_quiet();
    @(negedge clk);
    while (cells_pending.size() != 0 || in_valid || sums_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [8:0] w);
    wait_quiet();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_num_cols <= w;
    width_reg = w;
    restart_matrix();
    widths_written++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Cell driver: present the next queued transaction, with random gaps.
  always @(posedge clk) begin : drive_cells
    cell_t nxt;
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_path_sums(in_cell_value, in_end_of_matrix);
        cells_taken++;
      end
      if (!in_valid || in_ready) begin
        if (cells_pending.size() != 0 && !take_break()) begin
          nxt = cells_pending.pop_front();
          in_valid <= 1'b1;
          in_cell_value <= nxt.value;
          in_end_of_matrix <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every accepted transaction must match the oldest prediction.
  always @(posedge clk) begin : check_sums
    mfps_pkg::sum_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sums_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_min_path_sum);
        end else begin
          want = sums_due.pop_front();
          sums_checked++;
          if (out_min_path_sum !== want) begin
            errors++;
            $display("%0t: min_path_sum mismatch, expected %0d, actual %0d",
                     $time, want, out_min_path_sum);
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  // Stimulus: directed cases, then random matrices over many widths.
  initial begin : stimulus
    int unsigned p;
    int unsigned w_cfg;
    int unsigned w_eff;
    int unsigned mats;
    int unsigned rows;
    int unsigned n;
    int unsigned rand_cells;
    int r;
    foreach (row_sums[i]) row_sums[i] = '0;
    width_reg = 9'd1;
    restart_matrix();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset width of one: a single column, then a one-cell matrix.
    push_cell(32767, 1'b0);
    push_cell(-32768, 1'b0);
    push_cell(0, 1'b1);
    push_cell(-32768, 1'b1);

    // Three columns: a full 3x3 matrix, an end mark mid-row, and a single-row matrix.
    write_width(9'd3);
    push_cell(2, 1'b0); push_cell(1, 1'b0); push_cell(3, 1'b0);
    push_cell(6, 1'b0); push_cell(5, 1'b0); push_cell(4, 1'b0);
    push_cell(7, 1'b0); push_cell(8, 1'b0); push_cell(9, 1'b1);
    push_cell(1, 1'b0); push_cell(-2, 1'b0); push_cell(3, 1'b0);
    push_cell(4, 1'b1);
    push_cell(-5, 1'b0); push_cell(9, 1'b0); push_cell(-20, 1'b1);

    // A width of zero behaves as one.
    write_width(9'd0);
    push_cell(-7, 1'b0);
    push_cell(3, 1'b1);

    // A matrix abandoned by a width write gives no result.
    write_width(9'd2);
    push_cell(1, 1'b0); push_cell(2, 1'b0); push_cell(3, 1'b0);
    write_width(9'd4);
    push_cell(4, 1'b0); push_cell(3, 1'b0); push_cell(2, 1'b0); push_cell(1, 1'b1);

    // Random phases: extreme widths first, then mostly narrow ones.
    p = 0;
    rand_cells = 0;
    while (p < 5 || rand_cells < 780) begin
      case (p)
        0: w_cfg = 256;
        1: w_cfg = 511;
        2: w_cfg = 0;
        3: w_cfg = 1;
        4: w_cfg = 2;
        default: begin
          r = $urandom_range(99);
          if (r < 85) w_cfg = $urandom_range(1, 6);
          else w_cfg = $urandom_range(7, 24);
        end
      endcase
      w_eff = (w_cfg == 0) ? 1 : ((w_cfg > ROW_CAP) ? ROW_CAP : w_cfg);
      write_width(w_cfg[8:0]);
      mats = (w_eff > 40) ? 1 : $urandom_range(1, 3);
      for (int m = 0; m < mats; m++) begin
        rows = $urandom_range(1, 4);
        n = rows * w_eff;
        // Wide rows: one full row and the start of the next, so the wrap
        // after the last buffer column is seen.
        if (w_eff > 40) n = w_eff + 4;
        else if ($urandom_range(99) < 20) n = $urandom_range(1, n);
        for (int i = 0; i < n; i++) push_cell(pick_cell_value(), i == n - 1);
        rand_cells += n;
      end
      // Sometimes leave a matrix unfinished so the next write abandons it.
      if ($urandom_range(99) < 12) begin
        n = (w_eff > 40) ? $urandom_range(1, 5) : $urandom_range(1, 2 * w_eff + 1);
        for (int i = 0; i < n; i++) push_cell(pick_cell_value(), 1'b0);
        rand_cells += n;
      end
      p++;
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    $display("Run covered %0d cells over %0d width writes, with %0d path sums checked,",
             cells_taken, widths_written, sums_checked);
    $display("including zero and oversize widths, end marks mid-row and abandoned matrices.");
    if (errors == 0) begin
      $display("min_falling_path_sum_unit_tb: done, clean");
    end else begin
      $display("min_falling_path_sum_unit_tb: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("min_falling_path_sum_unit_tb: done, errors");
    $finish;
  end

endmodule
